[src/kvt_pkg.sv]
// ----------------------------------------------------------------------------
// kvt_pkg
// Shared types and constants for the key/value table: operation codes,
// default sizes and the result flag bundle.
// ----------------------------------------------------------------------------
package kvt_pkg;

    // Default sizes
    localparam int ENTRIES_DEF   = 16;
    localparam int KEY_BITS_DEF  = 32;
    localparam int DATA_BITS_DEF = 32;

    // Operation code width
    localparam int OP_BITS = 2;

    typedef enum logic [OP_BITS-1:0] {
        OP_SEARCH = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    // Status codes
    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // Result flags handed from the sequencer to the output stage
    typedef struct packed {
        logic found;
        logic status;
    } kvt_flags_t;

endpackage

[src/key_value_table.sv]
// ----------------------------------------------------------------------------
// key_value_table
// Dictionary of unique keys with one value each: search, insert/update and
// remove over a table of ENTRIES slots held in one memory.
// ----------------------------------------------------------------------------
// Each transaction reads every slot of the entry memory through its single
// read port, one slot per cycle, and then writes back in the ST_WRITE state,
// where the result is formed; the result then moves into the output register,
// and a new transaction is taken in the cycle its predecessor's result moves
// into the output register. After reset the block sweeps the memory clear,
// with in_ready low, before the first transaction. An insert of a new
// key into a full table returns status 1 and leaves the table unchanged;
// operation code 3 changes nothing and only reports whether the key is present.
// ----------------------------------------------------------------------------
module key_value_table #(
    parameter int ENTRIES   = kvt_pkg::ENTRIES_DEF,
    parameter int KEY_BITS  = kvt_pkg::KEY_BITS_DEF,
    parameter int DATA_BITS = kvt_pkg::DATA_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [kvt_pkg::OP_BITS-1:0]  operation,
    input  logic [KEY_BITS-1:0]          key,
    input  logic [DATA_BITS-1:0]         value_in,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         found,
    output logic [DATA_BITS-1:0]         value_out,
    output logic                         status
);

    import kvt_pkg::*;

    localparam int AW        = $clog2(ENTRIES);
    localparam int WORD_BITS = 1 + KEY_BITS + DATA_BITS;

    logic                 res_valid;
    logic                 res_ready;
    kvt_flags_t           res_flags;
    logic [DATA_BITS-1:0] res_value;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [AW-1:0]        mem_raddr;
    logic [WORD_BITS-1:0] mem_rdata;

    logic                 out_valid_reg;
    kvt_flags_t           out_flags_reg;
    logic [DATA_BITS-1:0] out_value_reg;

    kvt_ctrl #(
        .ENTRIES   (ENTRIES),
        .KEY_BITS  (KEY_BITS),
        .DATA_BITS (DATA_BITS),
        .AW        (AW),
        .WORD_BITS (WORD_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .key       (key),
        .value_in  (value_in),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_flags (res_flags),
        .res_value (res_value),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    kvt_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (ENTRIES),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Take a new result when the output register is empty or draining
    assign res_ready = !out_valid_reg || out_ready;

    // Hold the result until the consumer takes the transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_flags_reg <= '0;
            out_value_reg <= '0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
            if (res_valid)
            begin
                out_flags_reg <= res_flags;
                out_value_reg <= res_value;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign found     = out_flags_reg.found;
    assign status    = out_flags_reg.status;
    assign value_out = out_value_reg;

`ifndef NO_ASSERTIONS
    // A stalled result is not overwritten by the sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(value_out) && $stable(found)))
        else $error("pending result changed while stalled");

    // The sequencer never hands over a result while the output is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !res_ready)
        else $error("output register accepts while full");

    // Input and output never both advance from a blocked output
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |-> !in_ready)
        else $error("new transaction accepted while result is stuck");
`endif

endmodule

[src/kvt_ram.sv]
// ----------------------------------------------------------------------------
// kvt_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module kvt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/kvt_ctrl.sv]
// ----------------------------------------------------------------------------
// kvt_ctrl
// Sequencer of the key/value table: clears the entry memory after reset,
// scans every entry for a key match and the first free slot, then writes
// back the insert or remove and presents the result.
// ----------------------------------------------------------------------------
module kvt_ctrl #(
    parameter int ENTRIES   = kvt_pkg::ENTRIES_DEF,
    parameter int KEY_BITS  = kvt_pkg::KEY_BITS_DEF,
    parameter int DATA_BITS = kvt_pkg::DATA_BITS_DEF,
    parameter int AW        = $clog2(ENTRIES),
    parameter int WORD_BITS = 1 + KEY_BITS + DATA_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // request side
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [kvt_pkg::OP_BITS-1:0]  operation,
    input  logic [KEY_BITS-1:0]          key,
    input  logic [DATA_BITS-1:0]         value_in,
    // result side
    output logic                         res_valid,
    input  logic                         res_ready,
    output kvt_pkg::kvt_flags_t          res_flags,
    output logic [DATA_BITS-1:0]         res_value,
    // entry memory
    output logic                         mem_we,
    output logic [AW-1:0]                mem_waddr,
    output logic [WORD_BITS-1:0]         mem_wdata,
    output logic                         mem_re,
    output logic [AW-1:0]                mem_raddr,
    input  logic [WORD_BITS-1:0]         mem_rdata
);

    import kvt_pkg::*;

    localparam logic [AW-1:0] LAST_ADDR = AW'(ENTRIES - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } state_t;

    state_t               state_reg;
    logic [AW-1:0]        addr_reg;
    op_t                  op_reg;
    logic [KEY_BITS-1:0]  key_reg;
    logic [DATA_BITS-1:0] data_reg;
    logic                 hit_reg;
    logic [AW-1:0]        hit_addr_reg;
    logic [DATA_BITS-1:0] hit_value_reg;
    logic                 free_reg;
    logic [AW-1:0]        free_addr_reg;
    kvt_flags_t           flags_reg;
    logic [DATA_BITS-1:0] value_reg;

    logic                 start;
    logic                 last;
    logic                 word_valid;
    logic [KEY_BITS-1:0]  word_key;
    logic [DATA_BITS-1:0] word_value;
    logic                 match;

    // Split the memory word into its fields
    assign word_valid = mem_rdata[WORD_BITS-1];
    assign word_key   = mem_rdata[WORD_BITS-2 -: KEY_BITS];
    assign word_value = mem_rdata[DATA_BITS-1:0];
    assign match      = word_valid && (word_key == key_reg);
    assign last       = (addr_reg == LAST_ADDR);

    // Accept in idle, or straight out of done when the result leaves
    assign in_ready  = (state_reg == ST_IDLE) || ((state_reg == ST_DONE) && res_ready);
    assign start     = in_valid && in_ready;
    assign res_valid = (state_reg == ST_DONE);
    assign res_flags = flags_reg;
    assign res_value = value_reg;

    // Drive the memory ports
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
            end
            ST_SCAN:
            begin
                mem_re    = !last;
                mem_raddr = addr_reg + AW'(1);
            end
            ST_WRITE:
            begin
                if (op_reg == OP_INSERT)
                begin
                    mem_wdata = {1'b1, key_reg, data_reg};
                    if (hit_reg)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = hit_addr_reg;
                    end
                    else if (free_reg)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = free_addr_reg;
                    end
                end
                else if ((op_reg == OP_REMOVE) && hit_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = hit_addr_reg;
                end
            end
            default:
            begin
                mem_re = start;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            addr_reg      <= '0;
            op_reg        <= OP_NOP;
            key_reg       <= '0;
            data_reg      <= '0;
            hit_reg       <= 1'b0;
            hit_addr_reg  <= '0;
            hit_value_reg <= '0;
            free_reg      <= 1'b0;
            free_addr_reg <= '0;
            flags_reg     <= '0;
            value_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                // Sweep zero words through the memory
                ST_CLEAR:
                begin
                    if (last)
                    begin
                        addr_reg  <= '0;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        addr_reg <= addr_reg + AW'(1);
                    end
                end
                // Compare one entry per cycle, keep first match and first hole
                ST_SCAN:
                begin
                    if (match && !hit_reg)
                    begin
                        hit_reg       <= 1'b1;
                        hit_addr_reg  <= addr_reg;
                        hit_value_reg <= word_value;
                    end
                    if (!word_valid && !free_reg)
                    begin
                        free_reg      <= 1'b1;
                        free_addr_reg <= addr_reg;
                    end
                    if (last)
                    begin
                        state_reg <= ST_WRITE;
                    end
                    else
                    begin
                        addr_reg <= addr_reg + AW'(1);
                    end
                end
                // Write back and form the result
                ST_WRITE:
                begin
                    flags_reg.found  <= hit_reg;
                    flags_reg.status <= ((op_reg == OP_INSERT) && !hit_reg && !free_reg)
                                        ? STATUS_FULL : STATUS_DONE;
                    value_reg        <= ((op_reg == OP_SEARCH) && hit_reg)
                                        ? hit_value_reg : '0;
                    state_reg        <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (res_ready && !start)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                end
            endcase

            // Latch a new transaction and start the scan
            if (start)
            begin
                op_reg    <= op_t'(operation);
                key_reg   <= key;
                data_reg  <= value_in;
                hit_reg   <= 1'b0;
                free_reg  <= 1'b0;
                addr_reg  <= '0;
                state_reg <= ST_SCAN;
            end
        end
    end

`ifndef NO_ASSERTIONS
    // A full status only comes from an insert of an absent key
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res_flags.status == STATUS_FULL)) |->
            ((op_reg == OP_INSERT) && !res_flags.found))
        else $error("full status on a transaction that is not a missed insert");

    // A nonzero value only comes back from a search hit
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res_value != '0)) |-> ((op_reg == OP_SEARCH) && res_flags.found))
        else $error("value returned on a transaction that is not a search hit");

    // No write while the scan is still reading the memory
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !mem_we)
        else $error("memory write during scan");

    // An accepted transaction goes straight to the scan
    assert property (@(posedge clk) disable iff (!rst_n)
        start |=> ((state_reg == ST_SCAN) && (addr_reg == '0)))
        else $error("scan did not start at entry zero");
`endif

endmodule

[sim/key_value_table_tb.sv]
// ----------------------------------------------------------------------------
// key_value_table_tb
// Self-checking bench for the key/value table. A directed opening covers
// empty-table misses, no-op lookups, in-place updates, removes of absent keys
// and refused inserts into a full table. Four random phases follow, each with
// its own idle mix on both handshakes: a pool of related keys keeps the table
// busy with hits, fills and frees, and a share of fully random traffic adds
// noise. A shadow copy of the table predicts every result, and the monitor
// compares each result field by field in order.
// ----------------------------------------------------------------------------
module key_value_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kvt_pkg::*;

    localparam int SLOTS       = ENTRIES_DEF;
    localparam int KEY_W       = KEY_BITS_DEF;
    localparam int DATA_W      = DATA_BITS_DEF;
    localparam int CLK_HALF    = 6;
    localparam int RESET_LEN   = 7;
    localparam int POOL_SIZE   = 24;
    localparam int PHASE_ITEMS = 470;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_LEN   = 3 * SLOTS + 8;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        op_t               opcode;
        logic [KEY_W-1:0]  lookup_key;
        logic [DATA_W-1:0] data;
    } dict_op_t;

    typedef struct {
        logic              found;
        logic [DATA_W-1:0] value;
        logic              status;
    } dict_reply_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [OP_BITS-1:0] operation;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] value_in;
    logic              out_valid;
    logic              out_ready;
    logic              found;
    logic [DATA_W-1:0] value_out;
    logic              status;

    // Shadow copy of the table
    logic              shadow_used [SLOTS];
    logic [KEY_W-1:0]  shadow_key  [SLOTS];
    logic [DATA_W-1:0] shadow_val  [SLOTS];

    dict_op_t          pending_ops [$];
    dict_reply_t       replies_due [$];
    logic [KEY_W-1:0]  key_pool    [POOL_SIZE];
    dict_op_t          drive_op;

    logic              in_fired;
    int                send_idle_pct;
    int                recv_stall_pct;
    int                hold_left;
    int                cycle_count;
    int                error_count;
    int                ops_accepted;
    int                replies_checked;
    int                hit_count;
    int                full_count;

    key_value_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .key       (key),
        .value_in  (value_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .found     (found),
        .value_out (value_out),
        .status    (status)
    );

    initial clk = 1'b0;
    always #CLK_HALF clk = ~clk;

    // Apply one operation to the shadow table and return its result
    function automatic dict_reply_t apply_dict_op(op_t opc, logic [KEY_W-1:0] k,
                                                  logic [DATA_W-1:0] v);
        dict_reply_t r;
        int          hit;
        int          free_slot;
        hit       = -1;
        free_slot = -1;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (hit < 0 && shadow_used[i] && shadow_key[i] == k)
                hit = i;
            if (free_slot < 0 && !shadow_used[i])
                free_slot = i;
        end
        r.found  = (hit >= 0);
        r.value  = '0;
        r.status = STATUS_DONE;
        case (opc)
            OP_SEARCH:
            begin
                if (hit >= 0)
                    r.value = shadow_val[hit];
            end
            OP_INSERT:
            begin
                if (hit >= 0)
                    shadow_val[hit] = v;
                else if (free_slot >= 0)
                begin
                    shadow_used[free_slot] = 1'b1;
                    shadow_key[free_slot]  = k;
                    shadow_val[free_slot]  = v;
                end
                else
                    r.status = STATUS_FULL;
            end
            OP_REMOVE:
            begin
                if (hit >= 0)
                    shadow_used[hit] = 1'b0;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // Mostly pool keys with an insert bias so the table fills; some pure noise
    function automatic dict_op_t random_dict_op();
        dict_op_t t;
        int       pick;
        pick = $urandom_range(99);
        t.data = $urandom;
        if (pick < 8)
        begin
            t.opcode     = op_t'($urandom_range(3));
            t.lookup_key = $urandom;
        end
        else
        begin
            t.lookup_key = key_pool[$urandom_range(POOL_SIZE - 1)];
            if (pick < 46)
                t.opcode = OP_INSERT;
            else if (pick < 74)
                t.opcode = OP_SEARCH;
            else if (pick < 95)
                t.opcode = OP_REMOVE;
            else
                t.opcode = OP_NOP;
        end
        return t;
    endfunction

    task automatic queue_op(op_t opc, logic [KEY_W-1:0] k, logic [DATA_W-1:0] v);
        dict_op_t t;
        t.opcode     = opc;
        t.lookup_key = k;
        t.data       = v;
        pending_ops.push_back(t);
    endtask

    // Hold until every queued transaction went in and every result came back
    task automatic wait_drained();
        while (pending_ops.size() != 0 || in_valid || replies_due.size() != 0)
            @(negedge clk);
    endtask

    // Cycle count and timeout
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, replies_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Driver: advance to the next transaction once the current one is taken
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_fired))
        begin
            if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                drive_op = pending_ops.pop_front();
                in_valid  <= 1'b1;
                operation <= drive_op.opcode;
                key       <= drive_op.lookup_key;
                value_in  <= drive_op.data;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: hold off for a long stretch on request, else stall at random
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: check results in order, then predict newly accepted transactions
    always @(posedge clk)
    begin
        dict_reply_t exp_r;
        in_fired <= in_valid && in_ready;
        if (rst_n && out_valid && out_ready)
        begin
            if (replies_due.size() == 0)
            begin
                $error("result with no transaction outstanding: found=%0b value_out=%h status=%0b",
                       found, value_out, status);
                error_count++;
            end
            else
            begin
                exp_r = replies_due.pop_front();
                replies_checked++;
                if (found !== exp_r.found)
                begin
                    $error("found: expected %0b, got %0b", exp_r.found, found);
                    error_count++;
                end
                if (value_out !== exp_r.value)
                begin
                    $error("value_out: expected %h, got %h", exp_r.value, value_out);
                    error_count++;
                end
                if (status !== exp_r.status)
                begin
                    $error("status: expected %0b, got %0b", exp_r.status, status);
                    error_count++;
                end
            end
        end
        if (rst_n && in_valid && in_ready)
        begin
            exp_r = apply_dict_op(op_t'(operation), key, value_in);
            replies_due.push_back(exp_r);
            ops_accepted++;
            if (exp_r.found)
                hit_count++;
            if (exp_r.status == STATUS_FULL)
                full_count++;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_fired       = 1'b0;
        operation      = OP_SEARCH;
        key            = '0;
        value_in       = '0;
        out_ready      = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        cycle_count    = 0;
        error_count    = 0;
        ops_accepted   = 0;
        replies_checked = 0;
        hit_count      = 0;
        full_count     = 0;
        for (int i = 0; i < SLOTS; i++)
            shadow_used[i] = 1'b0;

        // Key pool: the directed keys plus a random key and one-bit neighbors
        for (int i = 0; i < SLOTS; i++)
            key_pool[i] = KEY_W'(i);
        key_pool[SLOTS]     = '1;
        key_pool[SLOTS + 1] = $urandom;
        for (int i = SLOTS + 2; i < POOL_SIZE; i++)
            key_pool[i] = key_pool[SLOTS + 1] ^ (KEY_W'(1) << $urandom_range(KEY_W - 1));

        repeat (RESET_LEN) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: misses, no-ops, extremes, update, absent remove, full table
        queue_op(OP_SEARCH, '0, '1);
        queue_op(OP_NOP, '1, '1);
        queue_op(OP_INSERT, '0, '1);
        queue_op(OP_INSERT, '1, '0);
        queue_op(OP_SEARCH, '0, '0);
        queue_op(OP_INSERT, '0, 32'h5a5a_a5a5);
        queue_op(OP_NOP, '0, '0);
        queue_op(OP_REMOVE, '1, '0);
        queue_op(OP_REMOVE, '1, '1);
        for (int i = 1; i < SLOTS; i++)
            queue_op(OP_INSERT, KEY_W'(i), $urandom);
        queue_op(OP_INSERT, '1, 32'hdead_beef);
        queue_op(OP_INSERT, KEY_W'(7), '1);
        wait_drained();

        // Random phases, each with its own idle mix
        for (int p = 0; p < 4; p++)
        begin
            @(posedge clk);
            case (p)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 55;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 55;
                end
                default:
                begin
                    send_idle_pct  = 22;
                    recv_stall_pct = 22;
                end
            endcase
            // Back-pressure the output while the sender keeps offering
            if (p == 0)
                hold_left = LONG_HOLD;
            repeat (PHASE_ITEMS) pending_ops.push_back(random_dict_op());
            wait_drained();
        end

        repeat (DRAIN_LEN) @(posedge clk);

        $display("%0d table operations checked over directed and four random phases",
                 replies_checked);
        $display("key present on %0d of them, %0d inserts refused by a full table",
                 hit_count, full_count);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
